>>> rtl/carm_pkg.sv
// Package for the Cardan angle rotation matrix core.
// Holds CORDIC constants and shared types. No dependencies.
package carm_pkg;

  localparam int CordicSteps = 24;
  localparam int StepIdxWidth = 5;
  localparam int QWidth = 34;  // Q30 values with headroom

  localparam logic signed [QWidth-1:0] CordicX0 = 34'sd652032874;

  typedef logic signed [QWidth-1:0] q_t;

  // One rotator's working values.
  typedef struct packed {
    q_t  x;
    q_t  y;
    q_t  z;
    logic flip;
  } rot_t;

  // Sine/cosine working values for all three angles.
  typedef struct packed {
    rot_t ax;
    rot_t ay;
    rot_t az;
  } trio_t;

  function automatic q_t atan_step(input logic [StepIdxWidth-1:0] idx);
    q_t r;
    r = '0;
    case (idx)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q30 x Q30 -> Q30 with round half up (floor of +2^29).
  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [2*QWidth-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return QWidth'(p >>> 30);
  endfunction

endpackage

>>> rtl/carm_if.sv
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface carm_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/carm_cell.sv
// One CORDIC cell: one micro-rotation on all three angles, registered.
// Depends on carm_pkg.
module carm_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           en,
  input  carm_pkg::trio_t din,
  output carm_pkg::trio_t dout
);

  localparam logic [carm_pkg::StepIdxWidth-1:0] Idx = carm_pkg::StepIdxWidth'(STEP);
  localparam carm_pkg::q_t Atan = carm_pkg::atan_step(Idx);

  function automatic carm_pkg::rot_t rot(input carm_pkg::rot_t r);
    carm_pkg::rot_t o;
    o = r;
    if (!r.z[carm_pkg::QWidth-1]) begin
      o.x = r.x - (r.y >>> STEP);
      o.y = r.y + (r.x >>> STEP);
      o.z = r.z - Atan;
    end else begin
      o.x = r.x + (r.y >>> STEP);
      o.y = r.y - (r.x >>> STEP);
      o.z = r.z + Atan;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      dout.ax <= rot(din.ax);
      dout.ay <= rot(din.ay);
      dout.az <= rot(din.az);
    end
  end

endmodule

>>> rtl/cardan_angles_rotation_matrix_core.sv
// Top level of the Cardan x-y-z angle to rotation matrix core.
// Depends on carm_pkg, carm_if and carm_cell.
//
// Usage: the in channel carries angle_x, angle_y, angle_z, binary angles
// with 2^ANGLE_WIDTH steps per turn. The out channel carries the nine
// matrix entries m00..m22, signed, OUT_FRAC_BITS fraction bits, clamped
// to +-1.0. One result item per input item, in order.
// Pipeline: 28 register stages (1 input register, 24 CORDIC cells, pair
// products, triple products, output register). The input register loads
// at the accepting edge, and out.valid rises when the item reaches the
// output register; a stall holds the item in place on the way.
// Throughput: one item per cycle while the receiver takes results; the row
// of 24 CORDIC cells, one micro-rotation each, is the path that sets it.
// Stall: the whole pipe advances as one. in.ready is high when the output
// register is empty or being taken, so a stalled receiver freezes the pipe
// and holds the last result steady.
// Reset: rst clears all valid bits; payload registers are not reset.
module cardan_angles_rotation_matrix_core #(
  parameter int ANGLE_WIDTH   = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input logic clk,
  input logic rst,
  carm_if.sink   in_ch,
  carm_if.source out_ch
);

  localparam int OutWidth = OUT_FRAC_BITS + 2;
  localparam int Shift = 30 - OUT_FRAC_BITS;
  localparam int Depth = 1 + carm_pkg::CordicSteps + 3;
  localparam int QW = carm_pkg::QWidth;

  // Pipe advances when the last stage is empty or taken.
  logic              adv;
  logic [Depth-1:0]  vld;

  assign adv = !vld[Depth-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_ch.valid};
    end
  end

  // Angle to CORDIC seed: fold into the right half plane.
  function automatic carm_pkg::rot_t seed(input logic [ANGLE_WIDTH-1:0] a);
    carm_pkg::rot_t r;
    logic [31:0] p;
    logic [ANGLE_WIDTH+31:0] w;
    w = {a, 32'd0} >> ANGLE_WIDTH;
    p = w[31:0];
    r.flip = p[31] ^ p[30];
    if (r.flip) begin
      p[31] = ~p[31];
    end
    r.x = carm_pkg::CordicX0;
    r.y = '0;
    r.z = QW'(signed'(p));
    return r;
  endfunction

  carm_pkg::trio_t chain [carm_pkg::CordicSteps+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      chain[0].ax <= seed(in_ch.data.angle_x[ANGLE_WIDTH-1:0]);
      chain[0].ay <= seed(in_ch.data.angle_y[ANGLE_WIDTH-1:0]);
      chain[0].az <= seed(in_ch.data.angle_z[ANGLE_WIDTH-1:0]);
    end
  end

  for (genvar g = 0; g < carm_pkg::CordicSteps; g++) begin : g_cell
    carm_cell #(.STEP(g)) u_cell (
      .clk (clk),
      .en  (adv),
      .din (chain[g]),
      .dout(chain[g+1])
    );
  end

  // Final sine/cosine with quadrant fix.
  carm_pkg::q_t sa, ca, sb, cb, sg, cg;
  carm_pkg::trio_t t;
  assign t = chain[carm_pkg::CordicSteps];
  assign sa = t.ax.flip ? -t.ax.y : t.ax.y;
  assign ca = t.ax.flip ? -t.ax.x : t.ax.x;
  assign sb = t.ay.flip ? -t.ay.y : t.ay.y;
  assign cb = t.ay.flip ? -t.ay.x : t.ay.x;
  assign sg = t.az.flip ? -t.az.y : t.az.y;
  assign cg = t.az.flip ? -t.az.x : t.az.x;

  // Product stage 1: pair products.
  carm_pkg::q_t p_sasb, p_casb, p_cbcg, p_cbsg, p_sacb, p_cacb;
  carm_pkg::q_t p_casg, p_sasg, p_cacg, p_sacg, r_sg, r_cg, r_sb;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_sasb <= carm_pkg::mulq(sa, sb);
      p_casb <= carm_pkg::mulq(ca, sb);
      p_cbcg <= carm_pkg::mulq(cb, cg);
      p_cbsg <= carm_pkg::mulq(cb, sg);
      p_sacb <= carm_pkg::mulq(sa, cb);
      p_cacb <= carm_pkg::mulq(ca, cb);
      p_casg <= carm_pkg::mulq(ca, sg);
      p_sasg <= carm_pkg::mulq(sa, sg);
      p_cacg <= carm_pkg::mulq(ca, cg);
      p_sacg <= carm_pkg::mulq(sa, cg);
      r_sg   <= sg;
      r_cg   <= cg;
      r_sb   <= sb;
    end
  end

  // Product stage 2: triple products and sums, in Q30.
  carm_pkg::q_t e [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      e[0] <= p_cbcg;
      e[1] <= carm_pkg::mulq(p_sasb, r_cg) + p_casg;
      e[2] <= p_sasg - carm_pkg::mulq(p_casb, r_cg);
      e[3] <= -p_cbsg;
      e[4] <= p_cacg - carm_pkg::mulq(p_sasb, r_sg);
      e[5] <= carm_pkg::mulq(p_casb, r_sg) + p_sacg;
      e[6] <= r_sb;
      e[7] <= -p_sacb;
      e[8] <= p_cacb;
    end
  end

  // Output format: round, then clamp to +-1.0.
  function automatic logic [OutWidth-1:0] to_out(input carm_pkg::q_t v);
    carm_pkg::q_t r;
    carm_pkg::q_t one;
    one = carm_pkg::q_t'(1) <<< OUT_FRAC_BITS;
    if (Shift > 0) begin
      r = (v + (carm_pkg::q_t'(1) <<< (Shift - 1))) >>> Shift;
    end else begin
      r = v;
    end
    if (r > one) begin
      r = one;
    end
    if (r < -one) begin
      r = -one;
    end
    return r[OutWidth-1:0];
  endfunction

  logic [OutWidth-1:0] o [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        o[k] <= to_out(e[k]);
      end
    end
  end

  assign out_ch.valid    = vld[Depth-1];
  assign out_ch.data.m00 = o[0];
  assign out_ch.data.m10 = o[1];
  assign out_ch.data.m20 = o[2];
  assign out_ch.data.m01 = o[3];
  assign out_ch.data.m11 = o[4];
  assign out_ch.data.m21 = o[5];
  assign out_ch.data.m02 = o[6];
  assign out_ch.data.m12 = o[7];
  assign out_ch.data.m22 = o[8];

`ifndef SYNTH
  // A held result must stay valid until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");
  // Ready only drops when the output register is full and stalled.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without cause");
  // An accepted item reaches the output once the pipe has advanced its full depth.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready ##1 adv [*Depth-1] |=> out_ch.valid)
    else $error("item lost in pipe");
`endif

endmodule

>>> dv/tb_cardan_angles_rotation_matrix_core.sv
// Testbench for cardan_angles_rotation_matrix_core: drives angle triples and checks
// each rotation matrix against an in-bench fixed-point CORDIC predictor.
// Depends on carm_if and the core RTL.
`timescale 1ns / 100ps

module tb_cardan_angles_rotation_matrix_core;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } angles_t;

  // Field order matches the output item: m00 in the top bits.
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m10;
    logic signed [15:0] m20;
    logic signed [15:0] m01;
    logic signed [15:0] m11;
    logic signed [15:0] m21;
    logic signed [15:0] m02;
    logic signed [15:0] m12;
    logic signed [15:0] m22;
  } matrix_t;

  localparam longint GainX0 = 652032874;
  localparam int Steps = 24;
  localparam longint AtanTab [Steps] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};
  localparam string EntryName [9] = '{
    "m00", "m10", "m20", "m01", "m11", "m21", "m02", "m12", "m22"};

  logic clk;
  logic rst;

  carm_if #(.payload_t(angles_t)) in_ch (clk);
  carm_if #(.payload_t(matrix_t)) out_ch (clk);

  cardan_angles_rotation_matrix_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  angles_t angle_queue[$];     // items waiting for the driver
  matrix_t matrix_queue[$];    // predicted matrices, oldest first
  int      send_idle_pct;
  int      recv_idle_pct;
  bit      long_hold_req;      // receiver holds off for a long stretch
  int      hold_cnt;
  bit      in_fire;            // in item taken at the last rising edge
  int      errors;
  int      n_results;

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------
  // Binary angle -> sine and cosine in Q30 via 24-step CORDIC.
  // Angles in the left half-plane are folded by a half turn and
  // the result negated afterwards.
  task automatic cordic_sincos(input logic [15:0] ang, output longint sin_q,
                               output longint cos_q);
    logic [31:0] phase;
    bit          fold;
    longint      x, y, z, dx, dy;
    phase = {ang, 16'h0000};
    fold  = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
    if (fold) phase[31] = ~phase[31];
    z = longint'($signed(phase));
    x = GainX0;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    if (fold) begin
      x = -x; y = -y;
    end
    sin_q = y;
    cos_q = x;
  endtask

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Q30 -> Q2.14, rounded half up, clamped to +-1.0.
  function automatic logic signed [15:0] q30_to_q14(input longint v);
    longint r;
    r = (v + (64'sd1 <<< 15)) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  task automatic predict_matrix(input angles_t a, output matrix_t m);
    longint sa, ca, sb, cb, sg, cg, sasb, casb;
    cordic_sincos(a.angle_x, sa, ca);
    cordic_sincos(a.angle_y, sb, cb);
    cordic_sincos(a.angle_z, sg, cg);
    sasb  = q30_mul(sa, sb);
    casb  = q30_mul(ca, sb);
    m.m00 = q30_to_q14(q30_mul(cb, cg));
    m.m10 = q30_to_q14(q30_mul(sasb, cg) + q30_mul(ca, sg));
    m.m20 = q30_to_q14(-q30_mul(casb, cg) + q30_mul(sa, sg));
    m.m01 = q30_to_q14(-q30_mul(cb, sg));
    m.m11 = q30_to_q14(-q30_mul(sasb, sg) + q30_mul(ca, cg));
    m.m21 = q30_to_q14(q30_mul(casb, sg) + q30_mul(sa, cg));
    m.m02 = q30_to_q14(sb);
    m.m12 = q30_to_q14(-q30_mul(sa, cb));
    m.m22 = q30_to_q14(q30_mul(ca, cb));
  endtask

  // ---------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // ---------------------------------------------------------------
  // Driver: offers items at the falling edge; holds an item until the
  // rising edge where it was taken.
  // ---------------------------------------------------------------
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst && (!in_ch.valid || in_fire)) begin
      if (angle_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= angle_queue.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready; the long hold-off is counted here.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold_req && hold_cnt < 300) begin
      hold_cnt     <= hold_cnt + 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------
  // Monitor: predict on input acceptance, compare on output acceptance
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    matrix_t exp_m;
    logic [143:0] exp_bits, act_bits;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_matrix(in_ch.data, exp_m);
        matrix_queue.push_back(exp_m);
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (matrix_queue.size() == 0) begin
          $error("result item with no prediction pending");
          errors++;
        end else begin
          exp_bits = matrix_queue.pop_front();
          act_bits = out_ch.data;
          for (int k = 0; k < 9; k++) begin
            if (exp_bits[143-16*k -: 16] !== act_bits[143-16*k -: 16]) begin
              $error("%s: expected %0d, got %0d", EntryName[k],
                     $signed(exp_bits[143-16*k -: 16]),
                     $signed(act_bits[143-16*k -: 16]));
              errors++;
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  function automatic logic [15:0] rand_angle();
    // Mostly uniform; some near eighth-turn multiples, incl. quarter turns where entries hit +-1.0.
    if ($urandom_range(3) == 0)
      return 16'($urandom_range(7) * 8192 + $signed($urandom_range(8)) - 4);
    return 16'($urandom);
  endfunction

  task automatic queue_random(input int n);
    angles_t a;
    repeat (n) begin
      a.angle_x = rand_angle();
      a.angle_y = rand_angle();
      a.angle_z = rand_angle();
      angle_queue.push_back(a);
    end
  endtask

  task automatic wait_drained();
    while (angle_queue.size() != 0 || in_ch.valid || matrix_queue.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] edge_vals [10];
    angles_t a;
    errors        = 0;
    n_results     = 0;
    hold_cnt      = 0;
    long_hold_req = 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 71;
    edge_vals = '{16'sd0, 16'sd1, -16'sd1, 16'sd16384, -16'sd16384, -16'sd32768,
                  16'sd32767, 16'sd8192, -16'sd8192, 16'sd24576};
    @(negedge rst);

    // Directed: extremes, quarter and half turns, each angle alone.
    foreach (edge_vals[i]) begin
      a = '{edge_vals[i], edge_vals[i], edge_vals[i]};
      angle_queue.push_back(a);
    end
    for (int i = 0; i < 4; i++) begin
      angle_queue.push_back('{edge_vals[i+3], 16'sd0, 16'sd0});
      angle_queue.push_back('{16'sd0, edge_vals[i+3], 16'sd0});
      angle_queue.push_back('{16'sd0, 16'sd0, edge_vals[i+3]});
    end
    angle_queue.push_back('{16'sd32767, -16'sd32768, 16'sd1});
    angle_queue.push_back('{-16'sd1, 16'sd16383, -16'sd16385});

    // Sender pauses here until every prediction has been matched.
    wait_drained();

    // Phase one, with a long receiver hold to back the pipe up.
    long_hold_req = 1'b1;
    queue_random(580);
    wait_drained();

    send_idle_pct = 71;
    recv_idle_pct = 38;
    queue_random(580);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(570);
    wait_drained();

    repeat (40) @(posedge clk);
    $display("tb: %0d matrices checked over directed angles and three idle mixes",
             n_results);
    if (errors == 0 && matrix_queue.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
